@@ rtl/assert_macros.svh @@
// Assertion helper macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/sm4_pkg.sv @@
// ---------------------------------------------------------------------------
// SM4 package
// Shared types, constants and functions for the SM4 chaining-mode engine.
// ---------------------------------------------------------------------------
package sm4_pkg;

    localparam int ROUND_COUNT = 32;
    localparam int RND_W = $clog2(ROUND_COUNT);

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic        restart;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } out_item_t;

    // Configuration register indexes
    localparam logic [2:0] REG_KEY_HIGH  = 3'd0;
    localparam logic [2:0] REG_KEY_LOW   = 3'd1;
    localparam logic [2:0] REG_TKEY_HIGH = 3'd2;
    localparam logic [2:0] REG_TKEY_LOW  = 3'd3;
    localparam logic [2:0] REG_IV_HIGH   = 3'd4;
    localparam logic [2:0] REG_IV_LOW    = 3'd5;
    localparam logic [2:0] REG_MODE      = 3'd6;
    localparam logic [2:0] REG_DECRYPT   = 3'd7;

    // Chaining mode codes
    localparam logic [2:0] MODE_ECB = 3'd0;
    localparam logic [2:0] MODE_CBC = 3'd1;
    localparam logic [2:0] MODE_CFB = 3'd2;
    localparam logic [2:0] MODE_OFB = 3'd3;
    localparam logic [2:0] MODE_CTR = 3'd4;
    localparam logic [2:0] MODE_XTS = 3'd5;

    localparam logic [127:0] FK = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

    // Control from the sequencer to the round unit.
    typedef struct packed {
        logic load;
        logic key_mode;
        logic step;
    } rnd_ctl_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'hd6; 8'h01: r=8'h90; 8'h02: r=8'he9; 8'h03: r=8'hfe;
            8'h04: r=8'hcc; 8'h05: r=8'he1; 8'h06: r=8'h3d; 8'h07: r=8'hb7;
            8'h08: r=8'h16; 8'h09: r=8'hb6; 8'h0a: r=8'h14; 8'h0b: r=8'hc2;
            8'h0c: r=8'h28; 8'h0d: r=8'hfb; 8'h0e: r=8'h2c; 8'h0f: r=8'h05;
            8'h10: r=8'h2b; 8'h11: r=8'h67; 8'h12: r=8'h9a; 8'h13: r=8'h76;
            8'h14: r=8'h2a; 8'h15: r=8'hbe; 8'h16: r=8'h04; 8'h17: r=8'hc3;
            8'h18: r=8'haa; 8'h19: r=8'h44; 8'h1a: r=8'h13; 8'h1b: r=8'h26;
            8'h1c: r=8'h49; 8'h1d: r=8'h86; 8'h1e: r=8'h06; 8'h1f: r=8'h99;
            8'h20: r=8'h9c; 8'h21: r=8'h42; 8'h22: r=8'h50; 8'h23: r=8'hf4;
            8'h24: r=8'h91; 8'h25: r=8'hef; 8'h26: r=8'h98; 8'h27: r=8'h7a;
            8'h28: r=8'h33; 8'h29: r=8'h54; 8'h2a: r=8'h0b; 8'h2b: r=8'h43;
            8'h2c: r=8'hed; 8'h2d: r=8'hcf; 8'h2e: r=8'hac; 8'h2f: r=8'h62;
            8'h30: r=8'he4; 8'h31: r=8'hb3; 8'h32: r=8'h1c; 8'h33: r=8'ha9;
            8'h34: r=8'hc9; 8'h35: r=8'h08; 8'h36: r=8'he8; 8'h37: r=8'h95;
            8'h38: r=8'h80; 8'h39: r=8'hdf; 8'h3a: r=8'h94; 8'h3b: r=8'hfa;
            8'h3c: r=8'h75; 8'h3d: r=8'h8f; 8'h3e: r=8'h3f; 8'h3f: r=8'ha6;
            8'h40: r=8'h47; 8'h41: r=8'h07; 8'h42: r=8'ha7; 8'h43: r=8'hfc;
            8'h44: r=8'hf3; 8'h45: r=8'h73; 8'h46: r=8'h17; 8'h47: r=8'hba;
            8'h48: r=8'h83; 8'h49: r=8'h59; 8'h4a: r=8'h3c; 8'h4b: r=8'h19;
            8'h4c: r=8'he6; 8'h4d: r=8'h85; 8'h4e: r=8'h4f; 8'h4f: r=8'ha8;
            8'h50: r=8'h68; 8'h51: r=8'h6b; 8'h52: r=8'h81; 8'h53: r=8'hb2;
            8'h54: r=8'h71; 8'h55: r=8'h64; 8'h56: r=8'hda; 8'h57: r=8'h8b;
            8'h58: r=8'hf8; 8'h59: r=8'heb; 8'h5a: r=8'h0f; 8'h5b: r=8'h4b;
            8'h5c: r=8'h70; 8'h5d: r=8'h56; 8'h5e: r=8'h9d; 8'h5f: r=8'h35;
            8'h60: r=8'h1e; 8'h61: r=8'h24; 8'h62: r=8'h0e; 8'h63: r=8'h5e;
            8'h64: r=8'h63; 8'h65: r=8'h58; 8'h66: r=8'hd1; 8'h67: r=8'ha2;
            8'h68: r=8'h25; 8'h69: r=8'h22; 8'h6a: r=8'h7c; 8'h6b: r=8'h3b;
            8'h6c: r=8'h01; 8'h6d: r=8'h21; 8'h6e: r=8'h78; 8'h6f: r=8'h87;
            8'h70: r=8'hd4; 8'h71: r=8'h00; 8'h72: r=8'h46; 8'h73: r=8'h57;
            8'h74: r=8'h9f; 8'h75: r=8'hd3; 8'h76: r=8'h27; 8'h77: r=8'h52;
            8'h78: r=8'h4c; 8'h79: r=8'h36; 8'h7a: r=8'h02; 8'h7b: r=8'he7;
            8'h7c: r=8'ha0; 8'h7d: r=8'hc4; 8'h7e: r=8'hc8; 8'h7f: r=8'h9e;
            8'h80: r=8'hea; 8'h81: r=8'hbf; 8'h82: r=8'h8a; 8'h83: r=8'hd2;
            8'h84: r=8'h40; 8'h85: r=8'hc7; 8'h86: r=8'h38; 8'h87: r=8'hb5;
            8'h88: r=8'ha3; 8'h89: r=8'hf7; 8'h8a: r=8'hf2; 8'h8b: r=8'hce;
            8'h8c: r=8'hf9; 8'h8d: r=8'h61; 8'h8e: r=8'h15; 8'h8f: r=8'ha1;
            8'h90: r=8'he0; 8'h91: r=8'hae; 8'h92: r=8'h5d; 8'h93: r=8'ha4;
            8'h94: r=8'h9b; 8'h95: r=8'h34; 8'h96: r=8'h1a; 8'h97: r=8'h55;
            8'h98: r=8'had; 8'h99: r=8'h93; 8'h9a: r=8'h32; 8'h9b: r=8'h30;
            8'h9c: r=8'hf5; 8'h9d: r=8'h8c; 8'h9e: r=8'hb1; 8'h9f: r=8'he3;
            8'ha0: r=8'h1d; 8'ha1: r=8'hf6; 8'ha2: r=8'he2; 8'ha3: r=8'h2e;
            8'ha4: r=8'h82; 8'ha5: r=8'h66; 8'ha6: r=8'hca; 8'ha7: r=8'h60;
            8'ha8: r=8'hc0; 8'ha9: r=8'h29; 8'haa: r=8'h23; 8'hab: r=8'hab;
            8'hac: r=8'h0d; 8'had: r=8'h53; 8'hae: r=8'h4e; 8'haf: r=8'h6f;
            8'hb0: r=8'hd5; 8'hb1: r=8'hdb; 8'hb2: r=8'h37; 8'hb3: r=8'h45;
            8'hb4: r=8'hde; 8'hb5: r=8'hfd; 8'hb6: r=8'h8e; 8'hb7: r=8'h2f;
            8'hb8: r=8'h03; 8'hb9: r=8'hff; 8'hba: r=8'h6a; 8'hbb: r=8'h72;
            8'hbc: r=8'h6d; 8'hbd: r=8'h6c; 8'hbe: r=8'h5b; 8'hbf: r=8'h51;
            8'hc0: r=8'h8d; 8'hc1: r=8'h1b; 8'hc2: r=8'haf; 8'hc3: r=8'h92;
            8'hc4: r=8'hbb; 8'hc5: r=8'hdd; 8'hc6: r=8'hbc; 8'hc7: r=8'h7f;
            8'hc8: r=8'h11; 8'hc9: r=8'hd9; 8'hca: r=8'h5c; 8'hcb: r=8'h41;
            8'hcc: r=8'h1f; 8'hcd: r=8'h10; 8'hce: r=8'h5a; 8'hcf: r=8'hd8;
            8'hd0: r=8'h0a; 8'hd1: r=8'hc1; 8'hd2: r=8'h31; 8'hd3: r=8'h88;
            8'hd4: r=8'ha5; 8'hd5: r=8'hcd; 8'hd6: r=8'h7b; 8'hd7: r=8'hbd;
            8'hd8: r=8'h2d; 8'hd9: r=8'h74; 8'hda: r=8'hd0; 8'hdb: r=8'h12;
            8'hdc: r=8'hb8; 8'hdd: r=8'he5; 8'hde: r=8'hb4; 8'hdf: r=8'hb0;
            8'he0: r=8'h89; 8'he1: r=8'h69; 8'he2: r=8'h97; 8'he3: r=8'h4a;
            8'he4: r=8'h0c; 8'he5: r=8'h96; 8'he6: r=8'h77; 8'he7: r=8'h7e;
            8'he8: r=8'h65; 8'he9: r=8'hb9; 8'hea: r=8'hf1; 8'heb: r=8'h09;
            8'hec: r=8'hc5; 8'hed: r=8'h6e; 8'hee: r=8'hc6; 8'hef: r=8'h84;
            8'hf0: r=8'h18; 8'hf1: r=8'hf0; 8'hf2: r=8'h7d; 8'hf3: r=8'hec;
            8'hf4: r=8'h3a; 8'hf5: r=8'hdc; 8'hf6: r=8'h4d; 8'hf7: r=8'h20;
            8'hf8: r=8'h79; 8'hf9: r=8'hee; 8'hfa: r=8'h5f; 8'hfb: r=8'h3e;
            8'hfc: r=8'hd7; 8'hfd: r=8'hcb; 8'hfe: r=8'h39; 8'hff: r=8'h48;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] tau(input logic [31:0] a);
        return {sbox(a[31:24]), sbox(a[23:16]), sbox(a[15:8]), sbox(a[7:0])};
    endfunction

    // CK word i: byte j is (4*i + j) * 7 mod 256.
    function automatic logic [31:0] ck_word(input logic [RND_W-1:0] i);
        logic [7:0] b0;
        b0 = 8'({i, 2'b00}) * 8'd7;
        return {b0, b0 + 8'd7, b0 + 8'd14, b0 + 8'd21};
    endfunction

endpackage

@@ rtl/sm4_block_cipher_modes_top.sv @@
// A block with a valid key schedule goes straight to the cipher rounds; a restart first runs
// the key schedule, and an XTS restart runs two schedules plus the tweak cipher.
// Rounds run one per cycle through a single shared round unit and a 32-entry round-key
// memory; a new block is accepted only once the engine is back in idle. A stalled result holds the
// engine in its final state until the output register frees up.
// Reset clears control, configuration and chaining state; round keys are not cleared.
// ---------------------------------------------------------------------------
// SM4 chaining-mode engine top level
// Sequencer around a shared SM4 round unit with ECB/CBC/CFB/OFB/CTR/XTS.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module sm4_block_cipher_modes_top
    import sm4_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TKEY  = 3'd1;
    localparam logic [2:0] ST_TWEAK = 3'd2;
    localparam logic [2:0] ST_DKEY  = 3'd3;
    localparam logic [2:0] ST_DATA  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [63:0]  key_high_reg, key_low_reg, tkey_high_reg, tkey_low_reg;
    logic [63:0]  iv_high_reg, iv_low_reg;
    logic [2:0]   mode_reg;
    logic         dec_reg;
    logic [127:0] chain_reg, chain_next;
    logic         sched_valid_reg;
    logic [2:0]   state_reg, state_next;
    logic [RND_W-1:0] cnt_reg, cnt_next;
    logic         first_reg, first_next;
    logic [127:0] blk_reg;
    out_item_t    out_reg;
    logic         out_valid_reg;

    logic [31:0]  rk_mem [ROUND_COUNT];
    logic [31:0]  rk_rd_reg;
    logic [RND_W-1:0] rd_addr;
    logic         rk_we;

    rnd_ctl_t     ctl;
    logic [127:0] load_data, result, pre, din;
    logic [31:0]  t_out, round_in;
    logic         in_fire, need_sched, eff_mode_xts;
    logic [2:0]   eff_mode;
    logic         last;
    logic         out_free;
    logic         use_dec;
    logic [127:0] ctr_inc, tw_dbl;

    assign in_fire  = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign eff_mode  = (mode_reg > MODE_XTS) ? MODE_ECB : mode_reg;
    assign eff_mode_xts = (eff_mode == MODE_XTS);
    assign need_sched = in_data.restart || !sched_valid_reg;
    assign last = (cnt_reg == RND_W'(ROUND_COUNT - 1));
    // Stream modes run the forward cipher in both directions.
    assign use_dec = dec_reg && !(eff_mode inside {MODE_CFB, MODE_OFB, MODE_CTR});

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0; key_low_reg <= '0;
            tkey_high_reg <= '0; tkey_low_reg <= '0;
            iv_high_reg <= '0; iv_low_reg <= '0;
            mode_reg <= MODE_ECB; dec_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_HIGH:  key_high_reg  <= cfg_data;
                REG_KEY_LOW:   key_low_reg   <= cfg_data;
                REG_TKEY_HIGH: tkey_high_reg <= cfg_data;
                REG_TKEY_LOW:  tkey_low_reg  <= cfg_data;
                REG_IV_HIGH:   iv_high_reg   <= cfg_data;
                REG_IV_LOW:    iv_low_reg    <= cfg_data;
                REG_MODE:      mode_reg      <= cfg_data[2:0];
                REG_DECRYPT:   dec_reg       <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Round key memory: written during a schedule, read through a register addressed by the next round index.
    assign rk_we = (state_reg == ST_TKEY || state_reg == ST_DKEY) && !first_reg;
    always_comb
    begin
        if (state_reg == ST_TWEAK || !use_dec)
        begin
            rd_addr = cnt_next;
        end
        else
        begin
            rd_addr = RND_W'(ROUND_COUNT - 1) - cnt_next;
        end
    end
    always_ff @(posedge clk)
    begin
        if (rk_we)
        begin
            rk_mem[cnt_reg] <= t_out;
        end
        rk_rd_reg <= rk_mem[rd_addr];
    end

    // Tweak key schedule writes, then its cipher, with the ENC order forced.
    assign round_in = (state_reg == ST_TKEY || state_reg == ST_DKEY) ? ck_word(cnt_reg)
                                                                     : rk_rd_reg;

    // Cipher input per mode
    always_comb
    begin
        din = {blk_reg};
        case (eff_mode)
            MODE_CBC: pre = dec_reg ? din : (din ^ chain_reg);
            MODE_CFB, MODE_OFB, MODE_CTR: pre = chain_reg;
            MODE_XTS: pre = din ^ chain_reg;
            default:  pre = din;
        endcase
    end

    // CTR increment: little-endian over bytes, byte 0 is the top byte.
    always_comb
    begin
        logic carry;
        carry = 1'b1;
        for (int i = 0; i < 16; i++)
        begin
            ctr_inc[127-8*i -: 8] = chain_reg[127-8*i -: 8] + {7'd0, carry};
            carry = carry && (chain_reg[127-8*i -: 8] == 8'hff);
        end
    end

    // XTS doubling: each byte shifts left with carry from the previous byte.
    always_comb
    begin
        tw_dbl[127:120] = {chain_reg[126:120], 1'b0} ^ (chain_reg[7] ? 8'h87 : 8'h00);
        for (int i = 1; i < 16; i++)
        begin
            tw_dbl[127-8*i -: 8] = {chain_reg[126-8*i -: 7], chain_reg[127-8*(i-1)]};
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        first_next = 1'b0;
        ctl        = '0;
        load_data  = pre;
        chain_next = chain_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_fire)
                begin
                    first_next = 1'b1;
                    if (need_sched)
                    begin
                        chain_next = {iv_high_reg, iv_low_reg};
                        state_next = eff_mode_xts ? ST_TKEY : ST_DKEY;
                    end
                    else
                    begin
                        state_next = ST_DATA;
                    end
                end
            end
            ST_TKEY, ST_DKEY:
            begin
                // First cycle loads key words; then one schedule round per cycle.
                ctl.key_mode = 1'b1;
                if (first_reg)
                begin
                    ctl.load  = 1'b1;
                    load_data = ((state_reg == ST_TKEY) ? {tkey_high_reg, tkey_low_reg}
                                                        : {key_high_reg, key_low_reg}) ^ FK;
                end
                else
                begin
                    ctl.step = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (last)
                    begin
                        first_next = 1'b1;
                        state_next = (state_reg == ST_TKEY) ? ST_TWEAK : ST_DATA;
                    end
                end
                if (first_reg)
                begin
                    cnt_next = '0;
                end
            end
            ST_TWEAK, ST_DATA:
            begin
                if (first_reg)
                begin
                    ctl.load  = 1'b1;
                    load_data = (state_reg == ST_TWEAK) ? chain_reg : pre;
                    cnt_next  = '0;
                end
                else
                begin
                    ctl.step = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (last)
                    begin
                        if (state_reg == ST_TWEAK)
                        begin
                            state_next = ST_DKEY;
                            first_next = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                // Hold the cipher result until the output register is free.
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (state_reg == ST_DONE && out_free)
        begin
            case (eff_mode)
                MODE_CBC: chain_next = dec_reg ? blk_reg : result;
                MODE_CFB: chain_next = dec_reg ? blk_reg : (result ^ blk_reg);
                MODE_OFB: chain_next = result;
                MODE_CTR: chain_next = ctr_inc;
                MODE_XTS: chain_next = tw_dbl;
                default:  chain_next = chain_reg;
            endcase
        end
        // Tweak result after its last round: reversed state with the final word.
        if (state_reg == ST_TWEAK && !first_reg && last)
        begin
            chain_next = {t_out, result[127:32]};
        end
    end

    // Output block formed per mode from the cipher result.
    logic [127:0] out_blk;
    always_comb
    begin
        case (eff_mode)
            MODE_CBC: out_blk = dec_reg ? (result ^ chain_reg) : result;
            MODE_CFB, MODE_OFB, MODE_CTR: out_blk = result ^ blk_reg;
            MODE_XTS: out_blk = result ^ chain_reg;
            default:  out_blk = result;
        endcase
    end

    // Control and data registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            first_reg       <= 1'b0;
            chain_reg       <= '0;
            sched_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
            chain_reg <= chain_next;
            if (state_reg == ST_DKEY && !first_reg && last)
            begin
                sched_valid_reg <= 1'b1;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            blk_reg <= {in_data.block_high, in_data.block_low};
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_reg <= out_blk;
        end
    end

    sm4_round u_round (
        .clk       (clk),
        .ctl       (ctl),
        .load_data (load_data),
        .round_in  (round_in),
        .t_out     (t_out),
        .result    (result)
    );

    `ASSERT_IMPL(a_stall_busy, clk, rst_n, state_reg != ST_IDLE, in_stall)
    `ASSERT_NEXT(a_data_has_sched, clk, rst_n, state_reg == ST_DONE, sched_valid_reg)
    `ASSERT_IMPL(a_cnt_idle, clk, rst_n, state_reg == ST_IDLE, cnt_reg == '0 || first_reg == 1'b0)

endmodule

@@ rtl/sm4_round.sv @@
// ---------------------------------------------------------------------------
// SM4 round unit
// One shared round datapath: four-word state, one cipher or key-schedule
// round per step, driven by the sequencer.
// ---------------------------------------------------------------------------
module sm4_round
    import sm4_pkg::*;
(
    input  logic         clk,
    input  rnd_ctl_t     ctl,
    input  logic [127:0] load_data,
    input  logic [31:0]  round_in,
    output logic [31:0]  t_out,
    output logic [127:0] result
);

    logic [127:0] state_reg;
    logic [31:0]  b;

    // Round function: key schedule uses L', cipher uses L.
    always_comb
    begin
        b = tau(state_reg[95:64] ^ state_reg[63:32] ^ state_reg[31:0] ^ round_in);
        if (ctl.key_mode)
        begin
            t_out = state_reg[127:96] ^ b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
        end
        else
        begin
            t_out = state_reg[127:96] ^ b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                  ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
        end
    end

    // State register: load or shift in the new word.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            state_reg <= load_data;
        end
        else if (ctl.step)
        begin
            state_reg <= {state_reg[95:0], t_out};
        end
    end

    // Final reverse transform.
    assign result = {state_reg[31:0], state_reg[63:32], state_reg[95:64], state_reg[127:96]};

endmodule
